[src/assert_macros.svh]
// Assertion helpers for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while in reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

[src/lpht_pkg.sv]
package lpht_pkg;

   // Field widths
   localparam int CMD_W      = 2;
   localparam int KEY_W      = 32;
   localparam int HASH_W     = 32;
   localparam int VALUE_W    = 64;
   localparam int LIMIT_W    = 6;
   localparam int COUNT_W    = 7;
   localparam int REQ_DATA_W = 128;
   localparam int RSP_DATA_W = 72;
   localparam int RSP_PAD_W  = RSP_DATA_W - VALUE_W - 1;

   localparam logic [LIMIT_W-1:0] LOAD_LIMIT_RESET = 6'd48;

   // Commands
   localparam logic [CMD_W-1:0] CMD_GET    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SET    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

   // Slot states
   localparam logic [1:0] SLOT_EMPTY = 2'd0;
   localparam logic [1:0] SLOT_LIVE  = 2'd1;
   localparam logic [1:0] SLOT_TOMB  = 2'd2;

   // One word of the slot memory: state over key
   typedef struct packed {
      logic [1:0]       state;
      logic [KEY_W-1:0] key;
   } slot_word_type;

   localparam int SLOT_W = $bits(slot_word_type);

endpackage

[src/linear_probe_hash_table.sv]
// Open-addressing hash table with linear probing and tombstones. CAPACITY
// slots (a power of two) of key, value and slot state live in two
// synchronous RAMs, read together one slot per cycle. Each request beat
// (get, set or delete) probes k slots (1 to CAPACITY): the first read is
// issued as the beat is taken, each slot is examined in the probe state,
// and write-back and the response follow in the done state, which waits
// while the output register is still full. After reset the slot states
// are swept to empty, one slot a cycle, so no request is taken until the
// sweep is done; load_limit writes are taken at any time. A response
// waiting in the output register does not block the next request until
// that request is ready to respond.
`include "assert_macros.svh"

module linear_probe_hash_table #(
   parameter int CAPACITY = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   // Request channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [lpht_pkg::CMD_W-1:0]          req_tuser,  // command
   input  logic [lpht_pkg::REQ_DATA_W-1:0]     req_tdata,  // key_id, key_hash, store_value
   // Response channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic                                rsp_tuser,  // status
   output logic [lpht_pkg::RSP_DATA_W-1:0]     rsp_tdata,  // found, read_value, zero pad
   // Load limit register
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [lpht_pkg::LIMIT_W-1:0]        csr_data
);

   localparam int AW = $clog2(CAPACITY);
   localparam logic [AW-1:0] LAST_SLOT = AW'(CAPACITY - 1);

   // Controller states
   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_PROBE = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   logic [1:0]                     fsm_ff, fsm_in;
   logic [AW-1:0]                  clr_ff, clr_in;
   logic [lpht_pkg::CMD_W-1:0]     cmd_ff, cmd_in;
   logic [lpht_pkg::KEY_W-1:0]     key_ff, key_in;
   logic [lpht_pkg::VALUE_W-1:0]   val_ff, val_in;
   logic [AW-1:0]                  idx_ff, idx_in;
   logic [AW-1:0]                  cnt_ff, cnt_in;
   logic                           tomb_v_ff, tomb_v_in;
   logic [AW-1:0]                  tomb_ff, tomb_in;
   logic                           hit_ff, hit_in;
   logic                           have_ff, have_in;
   logic                           fresh_ff, fresh_in;
   logic [AW-1:0]                  slot_ff, slot_in;
   logic [lpht_pkg::VALUE_W-1:0]   rval_ff, rval_in;
   logic [lpht_pkg::COUNT_W-1:0]   used_ff, used_in;
   logic [lpht_pkg::LIMIT_W-1:0]   limit_ff, limit_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           rsp_found_ff, rsp_found_in;
   logic                           rsp_status_ff, rsp_status_in;
   logic [lpht_pkg::VALUE_W-1:0]   rsp_value_ff, rsp_value_in;

   // RAM ports
   logic [AW-1:0]                  rd_addr;
   logic [lpht_pkg::SLOT_W-1:0]    slot_rd_raw;
   lpht_pkg::slot_word_type        slot_rd;
   logic [lpht_pkg::VALUE_W-1:0]   val_rd;
   logic                           slot_we;
   logic [AW-1:0]                  slot_wa;
   lpht_pkg::slot_word_type        slot_wd;
   logic                           val_we;

   // Probe and outcome terms
   logic                           req_beat;
   logic                           live_hit;
   logic                           is_tomb;
   logic                           is_empty;
   logic                           stop;
   logic                           out_free;
   logic                           fin;
   logic                           over_limit;
   logic                           do_slot_wr;
   logic [1:0]                     new_state;
   logic                           do_val_wr;
   logic                           res_found;
   logic                           res_status;
   logic [lpht_pkg::VALUE_W-1:0]   res_value;

   assign req_tready = (fsm_ff == ST_IDLE);
   assign req_beat   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign fin        = (fsm_ff == ST_DONE) && out_free;

   // Slot state and key store
   lpht_ram #(
      .WIDTH (lpht_pkg::SLOT_W),
      .DEPTH (CAPACITY)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_we),
      .wr_addr (slot_wa),
      .wr_data (slot_wd),
      .rd_addr (rd_addr),
      .rd_data (slot_rd_raw)
   );

   // Value store, read alongside the slot store
   lpht_ram #(
      .WIDTH (lpht_pkg::VALUE_W),
      .DEPTH (CAPACITY)
   ) u_value_ram (
      .clock   (clock),
      .wr_en   (val_we),
      .wr_addr (slot_ff),
      .wr_data (val_ff),
      .rd_addr (rd_addr),
      .rd_data (val_rd)
   );

   assign slot_rd = lpht_pkg::slot_word_type'(slot_rd_raw);

   // Read address: probe start on a request beat, next slot while probing
   always_comb begin
      unique case (fsm_ff)
         ST_IDLE:  rd_addr = req_tdata[lpht_pkg::KEY_W +: AW];
         ST_PROBE: rd_addr = idx_ff + 1'b1;
         default:  rd_addr = idx_ff;
      endcase
   end

   // Examine the slot read last cycle
   assign live_hit = (slot_rd.state == lpht_pkg::SLOT_LIVE) && (slot_rd.key == key_ff);
   assign is_tomb  = (slot_rd.state == lpht_pkg::SLOT_TOMB);
   assign is_empty = !(slot_rd.state == lpht_pkg::SLOT_LIVE) && !is_tomb;
   assign stop     = live_hit || is_empty || (cnt_ff == LAST_SLOT);

   // Outcome of the finished probe
   assign over_limit = ({1'b0, used_ff} + 8'd1) > {2'b00, limit_ff};

   always_comb begin
      do_slot_wr = 1'b0;
      new_state  = lpht_pkg::SLOT_LIVE;
      do_val_wr  = 1'b0;
      res_found  = 1'b0;
      res_status = 1'b0;
      res_value  = '0;
      case (cmd_ff)
         lpht_pkg::CMD_GET: begin
            res_found = hit_ff;
            res_value = hit_ff ? rval_ff : '0;
         end
         lpht_pkg::CMD_SET: begin
            if (!have_ff) begin
               res_status = 1'b1;
            end else if (hit_ff) begin
               do_val_wr = 1'b1;
            end else if (fresh_ff && over_limit) begin
               res_status = 1'b1;
            end else begin
               do_slot_wr = 1'b1;
               do_val_wr  = 1'b1;
               res_found  = 1'b1;
            end
         end
         lpht_pkg::CMD_DELETE: begin
            res_found  = hit_ff;
            do_slot_wr = hit_ff;
            new_state  = lpht_pkg::SLOT_TOMB;
         end
         default: begin
         end
      endcase
   end

   // RAM writes: clearing sweep, or write-back as the response is loaded
   always_comb begin
      if (fsm_ff == ST_CLEAR) begin
         slot_we       = 1'b1;
         slot_wa       = clr_ff;
         slot_wd.state = lpht_pkg::SLOT_EMPTY;
         slot_wd.key   = '0;
      end else begin
         slot_we       = fin && do_slot_wr;
         slot_wa       = slot_ff;
         slot_wd.state = new_state;
         slot_wd.key   = key_ff;
      end
   end
   assign val_we = fin && do_val_wr;

   // Controller next state
   always_comb begin
      fsm_in        = fsm_ff;
      clr_in        = clr_ff;
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      val_in        = val_ff;
      idx_in        = idx_ff;
      cnt_in        = cnt_ff;
      tomb_v_in     = tomb_v_ff;
      tomb_in       = tomb_ff;
      hit_in        = hit_ff;
      have_in       = have_ff;
      fresh_in      = fresh_ff;
      slot_in       = slot_ff;
      rval_in       = rval_ff;
      used_in       = used_ff;
      limit_in      = csr_valid ? csr_data : limit_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_found_in  = rsp_found_ff;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      unique case (fsm_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == LAST_SLOT) begin
               fsm_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_beat) begin
               cmd_in    = req_tuser;
               key_in    = req_tdata[0 +: lpht_pkg::KEY_W];
               val_in    = req_tdata[lpht_pkg::KEY_W + lpht_pkg::HASH_W +: lpht_pkg::VALUE_W];
               idx_in    = req_tdata[lpht_pkg::KEY_W +: AW];
               cnt_in    = '0;
               tomb_v_in = 1'b0;
               fsm_in    = ST_PROBE;
            end
         end
         ST_PROBE: begin
            // first tombstone passed is kept for reuse
            if (is_tomb && !tomb_v_ff) begin
               tomb_v_in = 1'b1;
               tomb_in   = idx_ff;
            end
            if (stop) begin
               fsm_in  = ST_DONE;
               hit_in  = live_hit;
               rval_in = val_rd;
               if (live_hit) begin
                  slot_in  = idx_ff;
                  have_in  = 1'b1;
                  fresh_in = 1'b0;
               end else if (is_empty) begin
                  slot_in  = tomb_v_ff ? tomb_ff : idx_ff;
                  have_in  = 1'b1;
                  fresh_in = !tomb_v_ff;
               end else begin
                  // wrapped with no empty slot
                  slot_in  = tomb_v_ff ? tomb_ff : idx_ff;
                  have_in  = tomb_v_ff || is_tomb;
                  fresh_in = 1'b0;
               end
            end else begin
               idx_in = idx_ff + 1'b1;
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_found_in  = res_found;
               rsp_status_in = res_status;
               rsp_value_in  = res_value;
               if ((cmd_ff == lpht_pkg::CMD_SET) && do_slot_wr && fresh_ff) begin
                  used_in = used_ff + 1'b1;
               end
               fsm_in = ST_IDLE;
            end
         end
         default: begin
            fsm_in = ST_CLEAR;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff       <= ST_CLEAR;
         clr_ff       <= '0;
         used_ff      <= '0;
         limit_ff     <= lpht_pkg::LOAD_LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         fsm_ff       <= fsm_in;
         clr_ff       <= clr_in;
         used_ff      <= used_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      val_ff        <= val_in;
      idx_ff        <= idx_in;
      cnt_ff        <= cnt_in;
      tomb_v_ff     <= tomb_v_in;
      tomb_ff       <= tomb_in;
      hit_ff        <= hit_in;
      have_ff       <= have_in;
      fresh_ff      <= fresh_in;
      slot_ff       <= slot_in;
      rval_ff       <= rval_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {{lpht_pkg::RSP_PAD_W{1'b0}}, rsp_value_ff, rsp_found_ff};

   // Checks
   `ASSERT_IMPLIES(a_wr_phase, clock, reset, slot_we || val_we, (fsm_ff == ST_CLEAR) || fin)
   `ASSERT_NEXT(a_beat_probes, clock, reset, req_beat, fsm_ff == ST_PROBE)
   `ASSERT_IMPLIES(a_refused_not_found, clock, reset, rsp_valid_ff && rsp_status_ff, !rsp_found_ff)
   `ASSERT_NEXT(a_used_step, clock, reset, 1'b1, (used_ff == $past(used_ff)) || (used_ff == $past(used_ff) + 1'b1))

endmodule

[src/lpht_ram.sv]
// Simple dual-port RAM: one write port, one read port, registered read data.
module lpht_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[test/lpht_check_pkg.sv]
package lpht_check_pkg;
   import lpht_pkg::*;

   localparam int SLOTS = 64;
   localparam int NO_SLOT = -1;
   localparam int MISMATCH_REPORT_MAX = 10;

   // One expected response beat
   typedef struct {
      logic               found;
      logic [VALUE_W-1:0] read_value;
      logic               status;
   } lookup_outcome_t;

   // Shadow copy of the table; predicts each response and checks it on arrival
   class lpht_shadow;
      logic [1:0]         slot_state [SLOTS];
      logic [KEY_W-1:0]   slot_key   [SLOTS];
      logic [VALUE_W-1:0] slot_value [SLOTS];
      int unsigned        used_count;
      logic [LIMIT_W-1:0] load_limit;
      lookup_outcome_t    pending_outcomes [$];
      int                 mismatch_count;

      function new();
         foreach (slot_state[i]) slot_state[i] = SLOT_EMPTY;
         used_count     = 0;
         load_limit     = LOAD_LIMIT_RESET;
         mismatch_count = 0;
      endfunction

      // Linear walk from the hashed slot; stops on a key match or an empty slot
      function void walk_chain(input logic [KEY_W-1:0] key, input logic [HASH_W-1:0] hash,
                               output bit hit, output int slot);
         int idx;
         int first_tomb;
         idx        = int'(hash & (SLOTS - 1));
         first_tomb = NO_SLOT;
         hit        = 1'b0;
         for (int n = 0; n < SLOTS; n++) begin
            if (slot_state[idx] == SLOT_LIVE) begin
               if (slot_key[idx] == key) begin
                  hit  = 1'b1;
                  slot = idx;
                  return;
               end
            end else if (slot_state[idx] == SLOT_TOMB) begin
               if (first_tomb == NO_SLOT) first_tomb = idx;
            end else begin
               slot = (first_tomb != NO_SLOT) ? first_tomb : idx;
               return;
            end
            idx = (idx + 1) % SLOTS;
         end
         // wrapped all the way round without meeting an empty slot
         slot = first_tomb;
      endfunction

      // Applies one accepted request beat and queues the response it should give
      function void note_request(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                                 input logic [HASH_W-1:0] hash,
                                 input logic [VALUE_W-1:0] value);
         lookup_outcome_t outcome;
         bit              hit;
         int              slot;
         bit              fresh;
         outcome = '{found: 1'b0, read_value: '0, status: 1'b0};
         case (cmd)
            CMD_GET: begin
               walk_chain(key, hash, hit, slot);
               if (hit) begin
                  outcome.found      = 1'b1;
                  outcome.read_value = slot_value[slot];
               end
            end
            CMD_SET: begin
               walk_chain(key, hash, hit, slot);
               if (slot == NO_SLOT) begin
                  outcome.status = 1'b1;
               end else if (hit) begin
                  slot_value[slot] = value;
               end else begin
                  fresh = (slot_state[slot] == SLOT_EMPTY);
                  if (fresh && (used_count + 1 > load_limit)) begin
                     outcome.status = 1'b1;
                  end else begin
                     if (fresh) used_count++;
                     slot_state[slot] = SLOT_LIVE;
                     slot_key[slot]   = key;
                     slot_value[slot] = value;
                     outcome.found    = 1'b1;
                  end
               end
            end
            CMD_DELETE: begin
               walk_chain(key, hash, hit, slot);
               if (hit) begin
                  slot_state[slot] = SLOT_TOMB;
                  outcome.found    = 1'b1;
               end
            end
            default: ;  // unknown command leaves the table alone
         endcase
         pending_outcomes.push_back(outcome);
      endfunction

      function void flag_mismatch(input string text);
         mismatch_count++;
         if (mismatch_count <= MISMATCH_REPORT_MAX) $display("%0t: mismatch: %s", $time, text);
      endfunction

      // Compares one response beat against the oldest expectation
      function void check_response(input logic found, input logic [VALUE_W-1:0] read_value,
                                   input logic status);
         lookup_outcome_t wanted;
         if (pending_outcomes.size() == 0) begin
            flag_mismatch($sformatf("unexpected response found %0b value %h status %0b",
                                    found, read_value, status));
            return;
         end
         wanted = pending_outcomes.pop_front();
         if (found !== wanted.found || read_value !== wanted.read_value ||
             status !== wanted.status)
            flag_mismatch($sformatf("expected found %0b value %h status %0b, got %0b %h %0b",
                                    wanted.found, wanted.read_value, wanted.status,
                                    found, read_value, status));
      endfunction
   endclass

endpackage

[test/tb_top.sv]
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import lpht_pkg::*;
   import lpht_check_pkg::*;

   localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;
   localparam int POOL_SIZE = 48;
   localparam int PHASE_COUNT = 5;
   localparam int ITEMS_PER_PHASE = 266;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [CMD_W-1:0]      req_tuser;   // command
   logic [REQ_DATA_W-1:0] req_tdata;   // key_id, key_hash, store_value
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic                  rsp_tuser;   // status
   logic [RSP_DATA_W-1:0] rsp_tdata;   // found, read_value, zero pad
   logic                  csr_valid;
   logic                  csr_ready;
   logic [LIMIT_W-1:0]    csr_data;

   lpht_shadow shadow;

   logic [KEY_W-1:0]  pool_key  [POOL_SIZE];
   logic [HASH_W-1:0] pool_hash [POOL_SIZE];
   int                req_quiet;
   int                rsp_quiet;
   int                phase_limit [PHASE_COUNT] = '{1, 12, 30, 63, 25};

   linear_probe_hash_table dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Wait before a beat: mostly a random gap, with occasional runs of back-to-back beats
   function automatic int draw_wait(inout int quiet_left);
      if (quiet_left > 0) begin
         quiet_left--;
         return 0;
      end
      if ($urandom_range(0, 19) == 0) begin
         quiet_left = $urandom_range(10, 40);
         return 0;
      end
      return $urandom_range(0, 17);
   endfunction

   // Watch all three channels at each edge
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) shadow.load_limit = csr_data;
         if (rsp_tvalid && rsp_tready)
            shadow.check_response(rsp_tdata[0], rsp_tdata[VALUE_W:1], rsp_tuser);
         if (req_tvalid && req_tready)
            shadow.note_request(req_tuser, req_tdata[KEY_W-1:0],
                                req_tdata[KEY_W +: HASH_W], req_tdata[KEY_W+HASH_W +: VALUE_W]);
      end
   end

   // Response side back-pressure
   initial begin
      int stall;
      rsp_tready <= 1'b0;
      rsp_quiet = 0;
      forever begin
         stall = draw_wait(rsp_quiet);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                               input logic [HASH_W-1:0] hash,
                               input logic [VALUE_W-1:0] value);
      int gap;
      gap = draw_wait(req_quiet);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {value, hash, key};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Let every outstanding response drain
   task automatic wait_drained();
      @(negedge clock);
      while (shadow.pending_outcomes.size() != 0) @(negedge clock);
   endtask

   // Load limit is only rewritten with the table idle
   task automatic write_limit(input logic [LIMIT_W-1:0] limit);
      req_tvalid <= 1'b0;
      wait_drained();
      repeat (4) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= limit;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // Mostly pool keys with clustered hashes so chains, wraps and tombstones build up
   task automatic random_request();
      int               roll;
      int               pick;
      logic [CMD_W-1:0] cmd;
      logic [KEY_W-1:0] key;
      logic [HASH_W-1:0] hash;
      roll = $urandom_range(0, 99);
      if (roll < 4)       cmd = CMD_UNKNOWN;
      else if (roll < 38) cmd = CMD_GET;
      else if (roll < 78) cmd = CMD_SET;
      else                cmd = CMD_DELETE;
      if ($urandom_range(0, 99) < 85) begin
         pick = $urandom_range(0, POOL_SIZE - 1);
         key  = pool_key[pick];
         hash = pool_hash[pick];
      end else begin
         key  = $urandom;
         hash = $urandom;
      end
      send_request(cmd, key, hash, {$urandom, $urandom});
   endtask

   initial begin
      int cluster;
      shadow = new();
      req_quiet = 0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tuser  <= CMD_GET;
      req_tdata  <= '0;
      csr_valid  <= 1'b0;
      csr_data   <= '0;

      // key pool: low hash bits bunched near both ends of the table
      for (int i = 0; i < POOL_SIZE; i++) begin
         cluster      = $urandom_range(0, 13);
         pool_key[i]  = $urandom;
         pool_hash[i] = {26'($urandom_range(0, (1 << 26) - 1)),
                         6'(cluster > 7 ? cluster + 50 : cluster)};
      end
      pool_key[0] = 32'h0000_0000;
      pool_key[1] = 32'hFFFF_FFFF;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty table, key zero, update, wrap from the top slot, tombstones
      send_request(CMD_GET,    32'h0000_0000, 32'h0000_0000, 64'h0);
      send_request(CMD_SET,    32'h0000_0000, 32'h0000_0000, 64'h0);
      send_request(CMD_GET,    32'h0000_0000, 32'h0000_0000, 64'h0);
      send_request(CMD_SET,    32'h0000_0000, 32'h0000_0000, 64'hFFFF_FFFF_FFFF_FFFF);
      send_request(CMD_GET,    32'h0000_0000, 32'h0000_0000, 64'h0);
      send_request(CMD_SET,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'h5555_5555_AAAA_AAAA);
      send_request(CMD_SET,    32'hA5A5_A5A5, 32'h0000_003F, 64'h0123_4567_89AB_CDEF);
      send_request(CMD_GET,    32'hA5A5_A5A5, 32'h0000_003F, 64'h0);
      send_request(CMD_DELETE, 32'h0000_0000, 32'h0000_0000, 64'h0);
      send_request(CMD_GET,    32'hA5A5_A5A5, 32'h0000_003F, 64'h0);
      send_request(CMD_SET,    32'h5A5A_5A5A, 32'h8000_0000, 64'hDEAD_BEEF_0000_0001);
      send_request(CMD_GET,    32'h0000_0000, 32'h0000_0000, 64'h0);
      send_request(CMD_DELETE, 32'h0000_0000, 32'h0000_0000, 64'h0);
      send_request(CMD_UNKNOWN, 32'hA5A5_A5A5, 32'h0000_003F, 64'hFFFF_FFFF_FFFF_FFFF);
      send_request(CMD_DELETE, 32'h5A5A_5A5A, 32'h8000_0000, 64'h0);
      send_request(CMD_DELETE, 32'h5A5A_5A5A, 32'h8000_0000, 64'h0);

      // Limit of zero: fresh slots refused, updates and tombstone reuse still go
      write_limit('0);
      send_request(CMD_SET,    32'h0000_0077, 32'h0000_0010, 64'h7);
      send_request(CMD_SET,    32'hA5A5_A5A5, 32'h0000_003F, 64'h1111_2222_3333_4444);
      send_request(CMD_SET,    32'h0F0F_0F0F, 32'h0000_0000, 64'h8000_0000_0000_0000);
      send_request(CMD_GET,    32'h0F0F_0F0F, 32'h0000_0000, 64'h0);

      // Random phases, each under its own load limit
      for (int p = 0; p < PHASE_COUNT; p++) begin
         write_limit(LIMIT_W'(phase_limit[p]));
         repeat (ITEMS_PER_PHASE) random_request();
      end

      req_tvalid <= 1'b0;
      wait_drained();
      repeat (80) @(posedge clock);
      if (shadow.mismatch_count == 0 && shadow.pending_outcomes.size() == 0)
         $display("linear_probe_hash_table verification clean");
      else
         $display("linear_probe_hash_table verification failed");
      $finish;
   end

   // Watchdog
   initial begin
      #8_000_000;
      $display("linear_probe_hash_table verification failed");
      $finish;
   end

endmodule
